>>> rtl/fpb_pkg.sv
// Shared types, constants and a helper function for the frame store blender.
package fpb_pkg;

	localparam int CFG_W          = 9;
	localparam int CH_W           = 8;
	localparam int COORD_W        = 16;
	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;

	localparam logic [CFG_W-1:0] SIZE_RESET    = 9'd256;
	localparam logic [CH_W-1:0]  ALPHA_OPAQUE  = 8'hFF;
	localparam logic [CH_W-1:0]  ALPHA_NONE    = 8'h00;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_BLEND = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_MIX,
		ST_WB
	} state_t;

	typedef struct packed {
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;
		logic [CH_W-1:0] a;
	} pixel_t;

	// Exact floor(n / 255) for any n up to 65279, which covers every blend sum.
	function automatic logic [CH_W-1:0] div255(input logic [15:0] n);
		logic [16:0] t;
		begin
			t = 17'(n) + 17'd1 + 17'(n[15:8]);
			return t[15:8];
		end
	endfunction

endpackage

>>> rtl/fpb_mix.sv
// Blend datapath: registered channel products, then divide by 255 and alpha select.
module fpb_mix import fpb_pkg::*; (
	input  logic   clk,
	input  logic   load,
	input  pixel_t src,
	input  pixel_t dst,
	output pixel_t blend,
	output pixel_t dst_s1
);

	logic [CH_W-1:0] inv_a;
	logic [15:0]     sum_r_s1;
	logic [15:0]     sum_g_s1;
	logic [15:0]     sum_b_s1;
	pixel_t          src_s1;
	logic [CH_W:0]   alpha_sum;
	logic [CH_W-1:0] alpha_sat;

	assign inv_a = ALPHA_OPAQUE - src.a;

	always_ff @(posedge clk) begin
		if (load) begin
			sum_r_s1 <= 16'(src.r) * 16'(src.a) + 16'(dst.r) * 16'(inv_a);
			sum_g_s1 <= 16'(src.g) * 16'(src.a) + 16'(dst.g) * 16'(inv_a);
			sum_b_s1 <= 16'(src.b) * 16'(src.a) + 16'(dst.b) * 16'(inv_a);
			src_s1   <= src;
			dst_s1   <= dst;
		end
	end

	assign alpha_sum = {1'b0, src_s1.a} + {1'b0, dst_s1.a};
	assign alpha_sat = alpha_sum[CH_W] ? ALPHA_OPAQUE : alpha_sum[CH_W-1:0];

	always_comb begin
		if (src_s1.a == ALPHA_NONE) begin
			blend = dst_s1;
		end else if (src_s1.a == ALPHA_OPAQUE) begin
			blend = src_s1;
		end else begin
			blend.r = div255(sum_r_s1);
			blend.g = div255(sum_g_s1);
			blend.b = div255(sum_b_s1);
			blend.a = alpha_sat;
		end
	end

endmodule

>>> rtl/framebuffer_pixel_blend_core.sv
// Top level of the RGBA frame store with write, read, blend and clear.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | in_valid, in_ready, opcode, x_pos, y_pos,  | into core
//          | red, green, blue, alpha                   |
//  output  | out_valid, out_ready, out_red, out_green,  | out of core
//          | out_blue, out_alpha, in_bounds            |
//  config  | cfg_we, cfg_index, cfg_data               | into core
//
// Write, read and blend pass from accept, with the store read issued, to forming
// the channel products, then to the divide and write-back.
// An out-of-bounds word goes from accept straight to write-back. Clear sweeps the
// single write port over every entry, one per cycle, and then goes to write-back.
// After reset the same sweep writes zeros to all MAX_WIDTH*MAX_HEIGHT entries
// (65536 by default) with in_ready low; configuration writes are taken throughout.
// A result waiting on out_ready does not stop the next word being accepted, but
// that word holds at write-back until the output register is free.
module framebuffer_pixel_blend_core import fpb_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [1:0]                opcode,
	input  logic signed [COORD_W-1:0] x_pos,
	input  logic signed [COORD_W-1:0] y_pos,
	input  logic [CH_W-1:0]           red,
	input  logic [CH_W-1:0]           green,
	input  logic [CH_W-1:0]           blue,
	input  logic [CH_W-1:0]           alpha,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [CH_W-1:0]           out_red,
	output logic [CH_W-1:0]           out_green,
	output logic [CH_W-1:0]           out_blue,
	output logic [CH_W-1:0]           out_alpha,
	output logic                      in_bounds,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [CFG_W-1:0]          cfg_data
);

	localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int XW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int YW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int EW     = $clog2(MAX_WIDTH + 1);
	localparam int HW     = $clog2(MAX_HEIGHT + 1);
	localparam int PW     = YW + EW + 1;

	pixel_t mem [DEPTH];

	state_t            state_q, state_d;
	logic [CFG_W-1:0]  width_q, height_q;
	logic [EW-1:0]     w_eff;
	logic [HW-1:0]     h_eff;
	logic              x_ok, y_ok, in_fire;
	logic [ADDR_W-1:0] rd_addr, addr_q, sweep_q;
	logic [XW-1:0]     x_idx;
	logic [YW-1:0]     y_idx;
	op_t               op_in, op_q;
	pixel_t            src_in, src_q, rd_q, blend_pix, dst_pix, wb_pix, out_pix_q;
	logic              inb_q, clr_q, out_inb_q, out_valid_q;
	logic              wb_go, mix_load, store_we, sweep_last;
	pixel_t            wr_pix;
	logic [ADDR_W-1:0] wr_addr;

	// Effective sizes: a register above the built size counts as the built size.
	assign w_eff = (32'(width_q) > 32'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : EW'(width_q);
	assign h_eff = (32'(height_q) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(height_q);

	assign op_in  = op_t'(opcode);
	assign src_in = '{r: red, g: green, b: blue, a: alpha};
	assign x_ok   = !x_pos[COORD_W-1] && (32'($unsigned(x_pos)) < 32'(w_eff));
	assign y_ok   = !y_pos[COORD_W-1] && (32'($unsigned(y_pos)) < 32'(h_eff));
	assign x_idx  = x_pos[XW-1:0];
	assign y_idx  = y_pos[YW-1:0];
	assign rd_addr = ADDR_W'(PW'(y_idx) * PW'(w_eff) + PW'(x_idx));
	assign in_fire = in_valid && in_ready;
	assign sweep_last = (sweep_q == ADDR_W'(DEPTH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIZE_RESET;
			height_q <= SIZE_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_SWEEP: begin
				if (sweep_last) state_d = clr_q ? ST_WB : ST_IDLE;
			end
			ST_IDLE: begin
				if (in_fire) begin
					if (op_in == OP_CLEAR) state_d = ST_SWEEP;
					else if (x_ok && y_ok) state_d = ST_MIX;
					else state_d = ST_WB;
				end
			end
			ST_MIX: state_d = ST_WB;
			ST_WB: begin
				if (!out_valid_q || out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control outputs of the sequencer.
	always_comb begin
		in_ready = 1'b0;
		mix_load = 1'b0;
		wb_go    = 1'b0;
		case (state_q)
			ST_IDLE:  in_ready = 1'b1;
			ST_MIX:   mix_load = 1'b1;
			ST_WB:    wb_go    = !out_valid_q || out_ready;
			ST_SWEEP: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
			sweep_q <= '0;
			clr_q   <= 1'b0;
			src_q   <= '0;
			op_q    <= OP_WRITE;
			inb_q   <= 1'b0;
			addr_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SWEEP) sweep_q <= sweep_last ? '0 : sweep_q + 1'b1;
			if (in_fire) begin
				op_q   <= op_in;
				src_q  <= src_in;
				addr_q <= rd_addr;
				inb_q  <= (op_in == OP_CLEAR) || (x_ok && y_ok);
				clr_q  <= (op_in == OP_CLEAR);
			end else if (wb_go) begin
				clr_q  <= 1'b0;
			end
		end
	end

	fpb_mix u_mix (
		.clk    (clk),
		.load   (mix_load),
		.src    (src_q),
		.dst    (rd_q),
		.blend  (blend_pix),
		.dst_s1 (dst_pix)
	);

	always_comb begin
		if (clr_q) begin
			wb_pix = src_q;
		end else if (!inb_q) begin
			wb_pix = '0;
		end else begin
			case (op_q)
				OP_WRITE: wb_pix = src_q;
				OP_READ:  wb_pix = dst_pix;
				OP_BLEND: wb_pix = blend_pix;
				default:  wb_pix = src_q;
			endcase
		end
	end

	// The sweep owns the write port; otherwise write-back of an in-bounds store update.
	always_comb begin
		if (state_q == ST_SWEEP) begin
			store_we = 1'b1;
			wr_addr  = sweep_q;
			wr_pix   = src_q;
		end else begin
			store_we = wb_go && inb_q && !clr_q && (op_q != OP_READ);
			wr_addr  = addr_q;
			wr_pix   = wb_pix;
		end
	end

	always_ff @(posedge clk) begin
		if (store_we) mem[wr_addr] <= wr_pix;
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (wb_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wb_go) begin
			out_pix_q <= wb_pix;
			out_inb_q <= inb_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_red   = out_pix_q.r;
	assign out_green = out_pix_q.g;
	assign out_blue  = out_pix_q.b;
	assign out_alpha = out_pix_q.a;
	assign in_bounds = out_inb_q;

endmodule

>>> rtl/fpb_checker.sv
// Port-level checker for the frame store blender, bound to the top level.
module fpb_checker import fpb_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic [1:0]                opcode,
	input logic signed [COORD_W-1:0] x_pos,
	input logic signed [COORD_W-1:0] y_pos,
	input logic [CH_W-1:0]           red,
	input logic [CH_W-1:0]           green,
	input logic [CH_W-1:0]           blue,
	input logic [CH_W-1:0]           alpha,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [CH_W-1:0]           out_red,
	input logic [CH_W-1:0]           out_green,
	input logic [CH_W-1:0]           out_blue,
	input logic [CH_W-1:0]           out_alpha,
	input logic                      in_bounds,
	input logic                      cfg_we,
	input logic                      cfg_index,
	input logic [CFG_W-1:0]          cfg_data
);

	// A stalled result stays offered and unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_green)
			&& $stable(out_blue) && $stable(out_alpha) && $stable(in_bounds))
		else $error("output word changed or dropped while stalled");

	// A miss carries transparent black.
	a_miss_black: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !in_bounds |-> out_red == '0 && out_green == '0
			&& out_blue == '0 && out_alpha == '0)
		else $error("out-of-bounds result is not transparent black");

	// Two words are never accepted back to back.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted on consecutive cycles");

	// A new result only appears once a word has been taken in.
	a_result_after_word: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without a word in flight");

endmodule

bind framebuffer_pixel_blend_core fpb_checker u_fpb_checker (.*);
